>>> rtl/sd_clock_divider_search_assert.svh
// Assertion macros shared by the SD clock divider search RTL.
`ifndef SD_CLOCK_DIVIDER_SEARCH_ASSERT_SVH
`define SD_CLOCK_DIVIDER_SEARCH_ASSERT_SVH

// Check a consequence in the same cycle.
`define SDCDS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sd clock divider search: same-cycle check failed");

// Check a consequence in the next cycle.
`define SDCDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sd clock divider search: next-cycle check failed");

`endif

>>> rtl/sdcds_pkg.sv
// Types and constants of the SD clock divider search.
package sdcds_pkg;

  localparam int RATE_W      = 32;
  localparam int SD_W        = 31;
  localparam int PRE_W       = 4;
  localparam int DIVIDEND_W  = 33;
  localparam int DIVISOR_W   = 5;
  localparam int QCNT_W      = 6;
  localparam int ADDR_W      = 3;

  localparam logic [RATE_W-1:0] XIN_LIMIT_RESET = 32'd260000000;
  localparam logic              REG_XIN_LIMIT   = 1'b0;

  typedef struct packed {
    logic [RATE_W-1:0] parent_rate;
    logic [RATE_W-1:0] target_rate;
  } req_t;

  typedef struct packed {
    logic [SD_W-1:0]   best_sd_rate;
    logic [PRE_W-1:0]  pre_divider;
    logic [RATE_W-1:0] xin_clk_rate;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_store;
    logic search_step;
    logic xdiv_start;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pre_last;
    logic search_last;
  } dp_status_t;

endpackage

>>> rtl/sd_clock_divider_search.sv
// Top level of the SD clock divider search: register port, controller, datapath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   req      | req_valid/req_ready | parent_rate, target_rate
//   rsp      | rsp_valid/rsp_ready | best_sd_rate, pre_divider, xin_clk_rate
//   config   | psel/penable/pwrite | xin_rate_limit at address 0
//
// A request holds the block through the accept cycle, MAX_PRE_DIVIDER+1 divisions (start,
// 33 quotient bits, store) on the shared bit-serial divider, the search steps, one more
// division for the rounded-up XIN rate and the output cycle.
// One request is worked on at a time; the output cycle waits while an earlier result sits
// unaccepted. Synchronous reset restores xin_rate_limit to 260000000.
`include "sd_clock_divider_search_assert.svh"

module sd_clock_divider_search #(
  parameter int MAX_PRE_DIVIDER = 10,
  parameter int MAX_SD_DIVIDER  = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  sdcds_pkg::req_t                  req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output sdcds_pkg::rsp_t                  rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdcds_pkg::ADDR_W-1:0]     paddr,
  input  logic [sdcds_pkg::RATE_W-1:0]     pwdata,
  output logic [sdcds_pkg::RATE_W-1:0]     prdata,
  output logic                             pready
);
  import sdcds_pkg::*;

  logic [RATE_W-1:0] xin_rate_limit;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_XIN_LIMIT) ? xin_rate_limit : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      xin_rate_limit <= XIN_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_XIN_LIMIT)) begin
      xin_rate_limit <= pwdata;
    end
  end

  sdcds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sdcds_datapath #(
    .MAX_PRE_DIVIDER (MAX_PRE_DIVIDER),
    .MAX_SD_DIVIDER  (MAX_SD_DIVIDER)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .xin_rate_limit (xin_rate_limit),
    .cmd            (cmd),
    .status         (status),
    .rsp            (rsp)
  );

  `SDCDS_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `SDCDS_ASSERT_SAME(a_pre_in_range, rsp_valid, rsp.pre_divider <= 4'(MAX_PRE_DIVIDER))
  `SDCDS_ASSERT_NEXT(a_load_sets_valid, cmd.result_load, rsp_valid && req_ready)

endmodule

>>> rtl/sdcds_divider.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module sdcds_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sdcds_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [sdcds_pkg::DIVISOR_W-1:0]    divisor,
  output logic [sdcds_pkg::DIVIDEND_W-1:0]   quotient,
  output logic                               done
);
  import sdcds_pkg::*;

  logic [DIVIDEND_W-1:0] quot;
  logic [DIVISOR_W-2:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [QCNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0]  trial;
  logic [DIVISOR_W-1:0]  diff;
  logic                  ge;

  assign trial    = {rem, quot[DIVIDEND_W-1]};
  assign ge       = trial >= dvsr;
  assign diff     = trial - dvsr;
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= QCNT_W'(DIVIDEND_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - QCNT_W'(1);
      done <= (cnt == QCNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (cnt != '0) begin
      quot <= {quot[DIVIDEND_W-2:0], ge};
      rem  <= ge ? diff[DIVISOR_W-2:0] : trial[DIVISOR_W-2:0];
    end
  end

endmodule

>>> rtl/sdcds_datapath.sv
// Datapath: XIN rate table, search over divider settings, result register.
module sdcds_datapath #(
  parameter int MAX_PRE_DIVIDER = 10,
  parameter int MAX_SD_DIVIDER  = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sdcds_pkg::req_t                 req,
  input  logic [sdcds_pkg::RATE_W-1:0]    xin_rate_limit,
  input  sdcds_pkg::ctrl_cmd_t            cmd,
  output sdcds_pkg::dp_status_t           status,
  output sdcds_pkg::rsp_t                 rsp
);
  import sdcds_pkg::*;

  localparam int NUM_PRE = MAX_PRE_DIVIDER + 1;
  localparam int IDX_W   = $clog2(NUM_PRE);
  localparam int NUM_K   = $clog2(MAX_SD_DIVIDER + 1) - 1;
  localparam int K_W     = $clog2(NUM_K + 1);
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(MAX_PRE_DIVIDER);
  localparam logic [K_W-1:0]   K_LAST   = K_W'(NUM_K);

  logic [RATE_W-1:0]     parent_rate;
  logic [RATE_W-1:0]     target_rate;
  logic [RATE_W-1:0]     xr [NUM_PRE];
  logic [PRE_W-1:0]      pre;
  logic [K_W-1:0]        k;
  logic [SD_W-1:0]       best;
  logic [PRE_W-1:0]      chosen;
  rsp_t                  rsp_q;

  logic [RATE_W-1:0]     xr_cur;
  logic [RATE_W-1:0]     sr_full;
  logic [RATE_W-1:0]     par_shift;
  logic [SD_W-1:0]       sr;
  logic                  early_stop;
  logic                  hit;
  logic                  k_end;
  logic                  pre_last;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quot;
  logic                  div_done;

  assign xr_cur     = xr[pre[IDX_W-1:0]];
  assign sr_full    = xr_cur >> k;
  assign sr         = sr_full[SD_W-1:0];
  assign par_shift  = parent_rate >> k;
  assign pre_last   = (pre == PRE_LAST);
  assign early_stop = (pre == '0) && (par_shift < {1'b0, best});
  assign hit        = (xr_cur <= xin_rate_limit) && ({1'b0, sr} <= target_rate);
  assign k_end      = hit || pre_last;

  assign status.div_done    = div_done;
  assign status.pre_last    = pre_last;
  assign status.search_last = early_stop || (k_end && (k == K_LAST));

  assign div_start    = cmd.div_start || cmd.xdiv_start;
  assign div_dividend = cmd.xdiv_start
                        ? ({1'b0, parent_rate} + {{(DIVIDEND_W-PRE_W){1'b0}}, chosen})
                        : {1'b0, parent_rate};
  assign div_divisor  = cmd.xdiv_start ? ({1'b0, chosen} + DIVISOR_W'(1))
                                       : ({1'b0, pre} + DIVISOR_W'(1));

  sdcds_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pre <= '0;
      k   <= K_W'(1);
    end else if (cmd.load) begin
      pre <= '0;
      k   <= K_W'(1);
    end else if (cmd.div_store) begin
      pre <= pre_last ? '0 : pre + PRE_W'(1);
    end else if (cmd.search_step && !early_stop) begin
      if (k_end) begin
        k   <= k + K_W'(1);
        pre <= '0;
      end else begin
        pre <= pre + PRE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      parent_rate <= req.parent_rate;
      target_rate <= req.target_rate;
      best        <= '0;
      chosen      <= PRE_LAST;
    end
    if (cmd.div_store) begin
      xr[pre[IDX_W-1:0]] <= div_quot[RATE_W-1:0];
    end
    if (cmd.search_step && !early_stop && hit && (sr >= best)) begin
      best   <= sr;
      chosen <= pre;
    end
    if (cmd.result_load) begin
      rsp_q.best_sd_rate <= best;
      rsp_q.pre_divider  <= chosen;
      rsp_q.xin_clk_rate <= div_quot[RATE_W-1:0];
    end
  end

  assign rsp = rsp_q;

endmodule

>>> rtl/sdcds_ctrl.sv
// Controller: sequences divisions, search and result hand-off.
module sdcds_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  sdcds_pkg::dp_status_t   status,
  output sdcds_pkg::ctrl_cmd_t    cmd
);
  import sdcds_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DIV_START = 3'd1;
  localparam logic [2:0] S_DIV_WAIT  = 3'd2;
  localparam logic [2:0] S_SEARCH    = 3'd3;
  localparam logic [2:0] S_XIN_START = 3'd4;
  localparam logic [2:0] S_XIN_WAIT  = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = status.pre_last ? S_SEARCH : S_DIV_START;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_last) begin
          state_next = S_XIN_START;
        end
      end
      S_XIN_START: begin
        cmd.xdiv_start = 1'b1;
        state_next     = S_XIN_WAIT;
      end
      S_XIN_WAIT: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sim/tb_sd_clock_divider_search.sv
// Testbench for the SD clock divider search: random and directed rate requests.
module tb_sd_clock_divider_search;
  timeunit 1ns;
  timeprecision 1ps;

  import sdcds_pkg::*;

  localparam int MAX_PRE_DIV = 10;
  localparam int MAX_SD_DIV  = 256;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 125;

  localparam logic [ADDR_W-1:0] XIN_LIMIT_ADDR = ADDR_W'(4 * int'(REG_XIN_LIMIT));
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR  = ADDR_W'(4 * (int'(REG_XIN_LIMIT) + 1));

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_item = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [RATE_W-1:0]   pwdata = '0;
  logic [RATE_W-1:0]   prdata;
  logic                pready;

  req_t        rate_requests[$];
  rsp_t        expected_settings[$];
  rsp_t        oldest_setting;
  logic [31:0] xin_limit_model = XIN_LIMIT_RESET;
  logic        req_taken = 1'b0;
  logic        idle_on = 1'b1;
  logic        failed = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_stall = 0;

  sd_clock_divider_search #(
    .MAX_PRE_DIVIDER(MAX_PRE_DIV),
    .MAX_SD_DIVIDER (MAX_SD_DIV)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rsp_t pick_divider(input logic [31:0] parent, input logic [31:0] target,
                                        input logic [31:0] limit);
    logic [63:0] p64;
    logic [63:0] best;
    logic [63:0] pre_sel;
    logic [63:0] sdiv;
    logic [63:0] xin;
    logic [63:0] sd;
    logic [63:0] rounded;
    int          pre;
    rsp_t        r;
    p64 = {32'd0, parent};
    best = 64'd0;
    pre_sel = 64'(MAX_PRE_DIV);
    for (sdiv = 64'd2; sdiv <= 64'(MAX_SD_DIV); sdiv = sdiv * 64'd2) begin
      if (p64 / sdiv < best) break;
      for (pre = 0; pre <= MAX_PRE_DIV; pre++) begin
        xin = p64 / 64'(pre + 1);
        sd = xin / sdiv;
        if (xin > {32'd0, limit}) continue;
        if (sd <= {32'd0, target}) begin
          if (sd >= best) begin
            best = sd;
            pre_sel = 64'(pre);
          end
          break;
        end
      end
    end
    rounded = (p64 + pre_sel) / (pre_sel + 64'd1);
    r.best_sd_rate = best[SD_W-1:0];
    r.pre_divider = pre_sel[PRE_W-1:0];
    r.xin_clk_rate = rounded[RATE_W-1:0];
    return r;
  endfunction

  function automatic req_t random_rate_request();
    req_t r;
    r.parent_rate = $urandom();
    r.target_rate = $urandom();
    case ($urandom_range(0, 9))
      0, 1: begin
      end
      2: begin
        r.parent_rate = $urandom_range(0, 40);
        r.target_rate = $urandom_range(0, 3);
      end
      3: begin
        r.target_rate = (r.parent_rate >> $urandom_range(1, 12)) + $urandom_range(0, 1);
      end
      4: begin
        r.target_rate = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      end
      default: begin
        r.parent_rate = 32'd12_000_000 * $urandom_range(1, 300);
        r.target_rate = $urandom_range(100_000, 210_000_000);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic add_request(input logic [31:0] parent, input logic [31:0] target);
    req_t r;
    r.parent_rate = parent;
    r.target_rate = target;
    rate_requests.push_back(r);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == XIN_LIMIT_ADDR) xin_limit_model = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rate_requests.size() != 0 || expected_settings.size() != 0 || req_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else if (!req_valid || req_taken) begin
      if (req_gap > 0) begin
        req_valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (rate_requests.size() > 0) begin
        req_valid <= 1'b1;
        req_item <= rate_requests.pop_front();
        if (idle_on && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 9);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response backpressure
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall <= 0;
    end else if (rsp_stall > 0) begin
      rsp_ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 15) == 0) rsp_stall <= $urandom_range(1, 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    req_taken <= !rst && req_valid && req_ready;
    if (!rst) begin
      if (req_valid && req_ready)
        expected_settings.push_back(pick_divider(req_item.parent_rate, req_item.target_rate,
                                                 xin_limit_model));
      if (rsp_valid && rsp_ready) begin
        if (expected_settings.size() == 0) begin
          $display("%0t: unexpected response, expected none, got %p", $time, rsp_data);
          failed = 1'b1;
        end else begin
          oldest_setting = expected_settings.pop_front();
          check_field("best_sd_rate", 32'(oldest_setting.best_sd_rate),
                      32'(rsp_data.best_sd_rate));
          check_field("pre_divider", 32'(oldest_setting.pre_divider), 32'(rsp_data.pre_divider));
          check_field("xin_clk_rate", oldest_setting.xin_clk_rate, rsp_data.xin_clk_rate);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          phase;
    int          n;
    logic [31:0] limit;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_request(32'd0, 32'd0);
    add_request(32'd0, 32'hFFFF_FFFF);
    add_request(32'hFFFF_FFFF, 32'd0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(32'd1, 32'd0);
    add_request(32'd7, 32'd0);
    add_request(32'd400_000_000, 32'd400_000);
    add_request(32'd400_000_000, 32'd50_000_000);
    add_request(32'd600_000_000, 32'd200_000_000);
    add_request(32'd260_000_000, 32'd130_000_000);
    add_request(32'd260_000_001, 32'd130_000_000);
    add_request(32'd2_860_000_000, 32'd25_000_000);
    add_request(32'd4_000_000_000, 32'd100_000_000);
    add_request(32'h5555_5555, 32'hAAAA_AAAA);
    add_request(32'hAAAA_AAAA, 32'h5555_5555);
    add_request(32'd1_000_000_000, 32'd1);
    wait_drained();

    reg_write(XIN_LIMIT_ADDR, 32'hFFFF_FFFF);
    reg_write(UNMAPPED_ADDR, 32'd0);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    add_request(32'd300_000_000, 32'd200_000_000);
    wait_drained();

    reg_write(XIN_LIMIT_ADDR, 32'd0);
    add_request(32'd0, 32'd0);
    add_request(32'd10, 32'd0);
    add_request(32'd11, 32'd5);
    add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: limit = XIN_LIMIT_RESET;
        1: limit = 32'd0;
        2: limit = 32'hFFFF_FFFF;
        3: limit = 32'd100_000_000;
        4: limit = $urandom();
        5: limit = $urandom_range(1, 1000);
        6: limit = $urandom_range(20_000_000, 400_000_000);
        default: limit = 32'd200_000_000;
      endcase
      if (phase == RAND_PHASES - 1) idle_on = 1'b0;
      reg_write(XIN_LIMIT_ADDR, limit);
      for (n = 0; n < PHASE_ITEMS; n++) rate_requests.push_back(random_rate_request());
      wait_drained();
    end

    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
